@@ hdl/stpl_pkg.sv @@
// Shared types and constants for the stereo true-peak lookahead limiter.
`default_nettype none

package stpl_pkg;

   // Register field widths
   localparam int CEIL_W  = 21;
   localparam int COEFF_W = 24;
   localparam int LOOK_W  = 8;
   localparam int OUT_W   = 22;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 2;

   // 0.18 in Q0.24 and its width
   localparam int JF_W = 22;
   localparam logic [JF_W-1:0] JUMP_FACTOR = 22'd3019899;

   // Unity in Q4.20
   localparam logic [31:0] UNITY = 32'd1048576;

   // Register reset values
   localparam logic [CEIL_W-1:0]  CEIL_RESET  = 21'd934254;
   localparam logic [COEFF_W-1:0] COEFF_RESET = 24'd16771392;
   localparam logic [LOOK_W-1:0]  LOOK_RESET  = 8'd72;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CEILING   = 2'd0,
      CSR_RELEASE   = 2'd1,
      CSR_LOOKAHEAD = 2'd2
   } csr_index_type;

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_JMP  = 9'b000000010,
      ST_EST  = 9'b000000100,
      ST_REL  = 9'b000001000,
      ST_UPD  = 9'b000010000,
      ST_MUL  = 9'b000100000,
      ST_LOAD = 9'b001000000,
      ST_DIV  = 9'b010000000,
      ST_FIN  = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

@@ hdl/stereo_true_peak_lookahead_limiter.sv @@
// Top level of the stereo true-peak lookahead limiter.
`default_nettype none

// Takes one stereo Q4.20 frame per transfer and returns one limited frame per
// transfer. The peak estimate is the larger channel magnitude plus 0.18 times
// the larger jump from the previous frame; the envelope attacks at once and
// releases by release_coeff. Frames are delayed lookahead_frames deep in a
// ring RAM (one read, one write per frame); outputs are zero with tuser low
// until the ring is primed, and the delay set at priming is kept afterwards.
// While the envelope is above the ceiling each delayed sample is scaled by
// ceiling / envelope (rounded) and then clipped to plus or minus one.
// When gain is applied the quotient comes from a bit-serial divider, which is
// skipped otherwise; a release adds an envelope update step before it. The
// finished result sits in an output register, so the next frame is taken
// meanwhile; no new frame is taken while the sequencer is busy with one.
// The ring needs no clearing after reset: no entry is read before it is written.
module stereo_true_peak_lookahead_limiter #(
   parameter int RING_DEPTH  = 256,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   // left_sample, right_sample
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // left_out, right_out
   output logic [47:0]                             rsp_tdata,
   // primed
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [stpl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [stpl_pkg::CSR_W-1:0]         csr_wdata
);

   import stpl_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int PW    = SB + 1 + JF_W;
   localparam int RW    = SB + COEFF_W;
   localparam int MW    = SB + CEIL_W;
   localparam int NW    = MW + 1;
   localparam int CNT_W = $clog2(SB + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
   localparam logic [PW-1:0]    ROUND    = PW'(1) << 23;

   // Configuration registers
   logic [CEIL_W-1:0]  ceil_ff;
   logic [COEFF_W-1:0] coeff_ff;
   logic [LOOK_W-1:0]  look_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_ff  <= CEIL_RESET;
         coeff_ff <= COEFF_RESET;
         look_ff  <= LOOK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CEILING:   ceil_ff  <= csr_wdata[CEIL_W-1:0];
            CSR_RELEASE:   coeff_ff <= csr_wdata[COEFF_W-1:0];
            CSR_LOOKAHEAD: look_ff  <= csr_wdata[LOOK_W-1:0];
            default: ;
         endcase
      end
   end

   // State
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic               filled_ff, filled_in;
   logic [SB-1:0]      env_ff, env_in;
   logic [SB-1:0]      prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic               emit_ff, emit_in;
   logic [SB-1:0]      inst_ff, inst_in;
   logic [SB:0]        jump_ff, jump_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [SB-1:0]      est_ff, est_in;
   logic [RW-1:0]      relp_ff, relp_in;
   logic [MW-1:0]      magp_ff [2];
   logic [MW-1:0]      magp_in [2];
   logic [SB-1:0]      rem_ff [2];
   logic [SB-1:0]      rem_in [2];
   logic [SB-1:0]      quo_ff [2];
   logic [SB-1:0]      quo_in [2];
   logic               neg_ff [2];
   logic               neg_in [2];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]   out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic               out_p_ff, out_p_in;

   // Ring RAM
   logic              accept;
   logic [2*SB-1:0]   ram_rdata;
   logic [SB-1:0]     in_l, in_r;

   assign in_l   = req_tdata[SB-1:0];
   assign in_r   = req_tdata[2*SB-1:SB];
   assign accept = req_tvalid && req_tready;

   stpl_ram #(
      .WIDTH (2*SB),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (accept),
      .waddr (wr_ff),
      .wdata ({in_r, in_l}),
      .re    (accept && filled_ff),
      .raddr (rd_ff),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_p_ff;
   assign rsp_tdata  = {4'b0, out_r_ff, out_l_ff};

   // Sequencer and datapath
   always_comb begin
      logic [SB:0]      dl, dr, ad, ar2;
      logic [SB-1:0]    al, ar;
      logic [IDX_W-1:0] wr_next;
      logic [SB-1:0]    x [2];
      logic [SB-1:0]    mag;
      logic [NW-1:0]    num;
      logic [SB:0]      trial;
      logic             ge;
      logic [CEIL_W-1:0] qs;
      logic [OUT_W-1:0] o [2];

      state_in     = state_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      filled_in    = filled_ff;
      env_in       = env_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      emit_in      = emit_ff;
      inst_in      = inst_ff;
      jump_in      = jump_ff;
      prod_in      = prod_ff;
      est_in       = est_ff;
      relp_in      = relp_ff;
      cnt_in       = cnt_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      out_p_in     = out_p_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      x[0]         = ram_rdata[SB-1:0];
      x[1]         = ram_rdata[2*SB-1:SB];
      mag          = '0;
      num          = '0;
      trial        = '0;
      ge           = 1'b0;
      qs           = '0;
      o[0]         = '0;
      o[1]         = '0;
      for (int i = 0; i < 2; i++) begin
         magp_in[i] = magp_ff[i];
         rem_in[i]  = rem_ff[i];
         quo_in[i]  = quo_ff[i];
         neg_in[i]  = neg_ff[i];
      end

      // Peak terms from the incoming frame
      al  = in_l[SB-1] ? (~in_l + 1'b1) : in_l;
      ar  = in_r[SB-1] ? (~in_r + 1'b1) : in_r;
      dl  = {in_l[SB-1], in_l} - {prev_l_ff[SB-1], prev_l_ff};
      dr  = {in_r[SB-1], in_r} - {prev_r_ff[SB-1], prev_r_ff};
      ad  = dl[SB] ? (~dl + 1'b1) : dl;
      ar2 = dr[SB] ? (~dr + 1'b1) : dr;
      wr_next = (wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               inst_in   = (al > ar) ? al : ar;
               jump_in   = (ad > ar2) ? ad : ar2;
               prev_l_in = in_l;
               prev_r_in = in_r;
               wr_in     = wr_next;
               if (!filled_ff) begin
                  emit_in   = 1'b0;
                  filled_in = 32'(wr_next) >= 32'(look_ff);
               end else begin
                  emit_in = 1'b1;
                  rd_in   = (rd_ff == LAST_IDX) ? '0 : rd_ff + 1'b1;
               end
               state_in = ST_JMP;
            end
         end
         ST_JMP: begin
            prod_in  = PW'(jump_ff) * PW'(JUMP_FACTOR);
            state_in = ST_EST;
         end
         ST_EST: begin
            est_in   = inst_ff + SB'((prod_ff + ROUND) >> 24);
            state_in = ST_REL;
         end
         ST_REL: begin
            if (est_ff > env_ff) begin
               env_in   = est_ff;
               state_in = ST_MUL;
            end else begin
               relp_in  = RW'(coeff_ff) * RW'(env_ff - est_ff);
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            env_in   = est_ff + SB'(relp_ff >> 24);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            for (int i = 0; i < 2; i++) begin
               mag        = x[i][SB-1] ? (~x[i] + 1'b1) : x[i];
               neg_in[i]  = x[i][SB-1];
               quo_in[i]  = mag;
               magp_in[i] = MW'(mag) * MW'(ceil_ff);
            end
            state_in = (emit_ff && (32'(env_ff) > 32'(ceil_ff))) ? ST_LOAD : ST_FIN;
         end
         ST_LOAD: begin
            for (int i = 0; i < 2; i++) begin
               num       = NW'(magp_ff[i]) + NW'(env_ff >> 1);
               rem_in[i] = SB'(num >> SB);
               quo_in[i] = num[SB-1:0];
            end
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per lane per cycle
            for (int i = 0; i < 2; i++) begin
               trial     = {rem_ff[i], quo_ff[i][SB-1]};
               ge        = trial >= {1'b0, env_ff};
               rem_in[i] = ge ? SB'(trial - {1'b0, env_ff}) : SB'(trial);
               quo_in[i] = {quo_ff[i][SB-2:0], ge};
            end
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == 32'(SB - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Clip to plus or minus one and restore sign
            for (int i = 0; i < 2; i++) begin
               qs   = (32'(quo_ff[i]) > UNITY) ? CEIL_W'(UNITY) : CEIL_W'(quo_ff[i]);
               o[i] = neg_ff[i] ? (~{1'b0, qs} + 1'b1) : {1'b0, qs};
               if (!emit_ff) begin
                  o[i] = '0;
               end
            end
            if (!out_valid_ff || rsp_tready) begin
               out_l_in     = o[0];
               out_r_in     = o[1];
               out_p_in     = emit_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ff        <= '0;
         rd_ff        <= '0;
         filled_ff    <= 1'b0;
         env_ff       <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         filled_ff    <= filled_in;
         env_ff       <= env_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      emit_ff  <= emit_in;
      inst_ff  <= inst_in;
      jump_ff  <= jump_in;
      prod_ff  <= prod_in;
      est_ff   <= est_in;
      relp_ff  <= relp_in;
      cnt_ff   <= cnt_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      out_p_ff <= out_p_in;
      for (int i = 0; i < 2; i++) begin
         magp_ff[i] <= magp_in[i];
         rem_ff[i]  <= rem_in[i];
         quo_ff[i]  <= quo_in[i];
         neg_ff[i]  <= neg_in[i];
      end
   end

endmodule

`default_nettype wire

@@ hdl/stpl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stpl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire
